### design/tum_pkg.sv
package tum_pkg;

  // default storage and word sizes
  localparam int TUM_MAX_PARTICLES = 4096;
  localparam int TUM_POS_BITS      = 32;

  // box length registers are unsigned Q15.16 in 31 bits
  localparam int TUM_LEN_W         = 31;
  localparam int TUM_CFG_IDX_W     = 2;
  localparam logic [TUM_LEN_W-1:0] TUM_LEN_RESET = 31'd65536;

  // configuration register indexes
  typedef enum logic [TUM_CFG_IDX_W-1:0] {
    CFG_BOX_X          = 2'd0,
    CFG_BOX_Y          = 2'd1,
    CFG_BOX_Z          = 2'd2,
    CFG_PARTICLE_COUNT = 2'd3
  } cfg_index_t;

endpackage

### design/trajectory_unfold_min_image.sv
// pipeline: memory read with the transfer, one difference stage, POS_BITS+1 restoring divide
//   stages, output register
// throughput: one item per cycle while the output is not stalled; an item whose particle index
//   is still in flight waits until the earlier item has written its reference back
// reset: synchronous, active high; clears the reference valid flag, the pipeline and the
//   output; box lengths return to 1.0; the reference memory is not cleared
module trajectory_unfold_min_image
  import tum_pkg::*;
#(
  parameter int MAX_PARTICLES = TUM_MAX_PARTICLES,
  parameter int POS_BITS      = TUM_POS_BITS,
  localparam int IDX_W        = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [TUM_CFG_IDX_W-1:0]    cfg_index,
  input  logic [TUM_LEN_W-1:0]        cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [IDX_W-1:0]            particle_index,
  input  logic signed [POS_BITS-1:0]  pos_x,
  input  logic signed [POS_BITS-1:0]  pos_y,
  input  logic signed [POS_BITS-1:0]  pos_z,
  input  logic                        restart_reference,
  input  logic                        frame_last,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [POS_BITS-1:0]  out_x,
  output logic signed [POS_BITS-1:0]  out_y,
  output logic signed [POS_BITS-1:0]  out_z,
  output logic                        was_unfolded,
  output logic                        saturated,
  output logic                        out_frame_last
);

  localparam int LEN_W     = TUM_LEN_W;
  localparam int DEPTH     = 1 << IDX_W;
  localparam int MAG_W     = POS_BITS + 1;
  localparam int DIV_STEPS = MAG_W;
  localparam int NS        = DIV_STEPS + 2;
  localparam int RES_W     = ((POS_BITS > LEN_W) ? POS_BITS : LEN_W) + 3;
  localparam logic signed [RES_W-1:0] POS_MAX =
    RES_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] POS_MIN = -POS_MAX - RES_W'(1);

  typedef struct packed {
    logic [POS_BITS-1:0] ref_pos;
    logic                neg;
    logic                bypass;
    logic [MAG_W-1:0]    mag;
    logic [LEN_W-1:0]    rem;
    logic                qbit;
  } axis_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             unfold;
    logic             last;
    axis_t [2:0]      ax;
  } stage_t;

  // configuration registers and reference flag
  logic [LEN_W-1:0] box_len [3];
  logic             ref_valid;

  // reference memory
  logic [3*POS_BITS-1:0] ref_mem [DEPTH];
  logic [3*POS_BITS-1:0] rdata;

  // pipeline
  stage_t        st [NS];
  stage_t        st_next [NS];
  logic [NS-1:0] sv;
  logic [NS-1:0] adv;
  logic [NS-1:0] mv;
  logic          out_free;
  logic          hit;
  logic          accept;
  logic          unfold_in;

  // final stage results
  logic signed [POS_BITS-1:0] res [3];
  logic [2:0]                 sat_ax;
  logic [3*POS_BITS-1:0]      wdata;

  // stage hand-over chain, bubbles collapse
  always_comb begin
    out_free = !out_valid || !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      if (k == NS - 1) begin
        mv[k] = sv[k] && out_free;
      end else begin
        mv[k] = sv[k] && adv[k+1];
      end
      adv[k] = !sv[k] || mv[k];
    end
  end

  // interlock on a particle still in flight
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NS; k++) begin
      if (sv[k] && (st[k].idx == particle_index)) begin
        hit = 1'b1;
      end
    end
  end

  assign in_stall  = !adv[0] || hit;
  assign accept    = in_valid && !in_stall;
  assign unfold_in = ref_valid && !restart_reference;

  // stage contents: entry, difference, divide steps
  always_comb begin
    logic signed [POS_BITS:0] d;
    logic [POS_BITS-1:0]      pos;
    logic [POS_BITS-1:0]      rv;
    logic [LEN_W:0]           r2;
    logic                     ge;
    d   = '0;
    pos = '0;
    rv  = '0;
    r2  = '0;
    ge  = 1'b0;
    for (int k = 0; k < NS; k++) begin
      st_next[k] = st[k];
    end
    // entry: positions ride in ref_pos until the reference arrives
    st_next[0].idx    = particle_index;
    st_next[0].unfold = unfold_in;
    st_next[0].last   = frame_last;
    st_next[0].ax     = '0;
    st_next[0].ax[0].ref_pos = pos_x;
    st_next[0].ax[1].ref_pos = pos_y;
    st_next[0].ax[2].ref_pos = pos_z;
    // difference to the stored reference
    st_next[1] = st[0];
    for (int a = 0; a < 3; a++) begin
      pos = st[0].ax[a].ref_pos;
      rv  = rdata[a*POS_BITS +: POS_BITS];
      d   = $signed({pos[POS_BITS-1], pos}) - $signed({rv[POS_BITS-1], rv});
      st_next[1].ax[a].bypass  = !st[0].unfold || (box_len[a] == '0);
      st_next[1].ax[a].ref_pos = st_next[1].ax[a].bypass ? pos : rv;
      st_next[1].ax[a].neg     = d[POS_BITS];
      st_next[1].ax[a].mag     = d[POS_BITS] ? MAG_W'(-d) : MAG_W'(d);
      st_next[1].ax[a].rem     = '0;
      st_next[1].ax[a].qbit    = 1'b0;
    end
    // one restoring divide step per stage
    for (int k = 2; k < NS; k++) begin
      st_next[k] = st[k-1];
      for (int a = 0; a < 3; a++) begin
        r2 = {st[k-1].ax[a].rem, st[k-1].ax[a].mag[MAG_W-1]};
        ge = r2 >= {1'b0, box_len[a]};
        st_next[k].ax[a].mag  = {st[k-1].ax[a].mag[MAG_W-2:0], 1'b0};
        st_next[k].ax[a].rem  = ge ? LEN_W'(r2 - {1'b0, box_len[a]}) : r2[LEN_W-1:0];
        st_next[k].ax[a].qbit = ge;
      end
    end
  end

  // rounding to nearest even, centred remainder, saturation
  always_comb begin
    logic [LEN_W:0]          twice;
    logic                    up;
    logic signed [RES_W-1:0] cen;
    logic signed [RES_W-1:0] rw;
    logic signed [RES_W-1:0] sum;
    twice = '0;
    up    = 1'b0;
    cen   = '0;
    rw    = '0;
    sum   = '0;
    for (int a = 0; a < 3; a++) begin
      twice = {st[NS-1].ax[a].rem, 1'b0};
      up    = (twice > {1'b0, box_len[a]}) ||
              ((twice == {1'b0, box_len[a]}) && st[NS-1].ax[a].qbit);
      cen   = up ? $signed(RES_W'(st[NS-1].ax[a].rem)) - $signed(RES_W'(box_len[a]))
                 : $signed(RES_W'(st[NS-1].ax[a].rem));
      rw    = RES_W'($signed(st[NS-1].ax[a].ref_pos));
      sum   = st[NS-1].ax[a].neg ? rw - cen : rw + cen;
      sat_ax[a] = 1'b0;
      if (st[NS-1].ax[a].bypass) begin
        res[a] = st[NS-1].ax[a].ref_pos;
      end else if (sum > POS_MAX) begin
        res[a]    = POS_MAX[POS_BITS-1:0];
        sat_ax[a] = 1'b1;
      end else if (sum < POS_MIN) begin
        res[a]    = POS_MIN[POS_BITS-1:0];
        sat_ax[a] = 1'b1;
      end else begin
        res[a] = sum[POS_BITS-1:0];
      end
    end
    wdata = {res[2], res[1], res[0]};
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      if (adv[0]) begin
        sv[0] <= accept;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          sv[k] <= mv[k-1];
        end
      end
    end
    if (accept) begin
      st[0] <= st_next[0];
    end
    for (int k = 1; k < NS; k++) begin
      if (mv[k-1]) begin
        st[k] <= st_next[k];
      end
    end
  end

  // reference memory: read on transfer, write back as the result leaves
  always_ff @(posedge clk) begin
    if (mv[NS-1]) begin
      ref_mem[st[NS-1].idx] <= wdata;
    end
    if (accept) begin
      rdata <= ref_mem[particle_index];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mv[NS-1];
    end
    if (mv[NS-1]) begin
      out_x          <= res[0];
      out_y          <= res[1];
      out_z          <= res[2];
      was_unfolded   <= st[NS-1].unfold;
      saturated      <= |sat_ax;
      out_frame_last <= st[NS-1].last;
    end
  end

  // configuration and reference flag
  always_ff @(posedge clk) begin
    if (rst) begin
      box_len[0] <= TUM_LEN_RESET;
      box_len[1] <= TUM_LEN_RESET;
      box_len[2] <= TUM_LEN_RESET;
      ref_valid  <= 1'b0;
    end else begin
      if (accept && !unfold_in && frame_last) begin
        ref_valid <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_BOX_X:          box_len[0] <= cfg_data;
          CFG_BOX_Y:          box_len[1] <= cfg_data;
          CFG_BOX_Z:          box_len[2] <= cfg_data;
          CFG_PARTICLE_COUNT: ref_valid  <= 1'b0;
          default:            ;
        endcase
      end
    end
  end

  // checks
  a_hazard_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && hit) |-> in_stall)
    else $error("transfer taken while the same particle is in flight");

  a_pass_no_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !was_unfolded) |-> !saturated)
    else $error("pass-through result flagged as saturated");

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == CFG_PARTICLE_COUNT)) |=> !ref_valid)
    else $error("particle count write left the reference valid");

endmodule
